>>> hdl/lfcrc_pkg.sv
// ----------------------------------------------------------------------------
// lfcrc_pkg
// Shared types, constants and the byte-wide CRC-16 update for the
// length-framed response checker.
// ----------------------------------------------------------------------------
package lfcrc_pkg;

    localparam int unsigned FIFO_DEPTH = 4;

    localparam logic [15:0] CRC_PRESET = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'h8408;
    localparam logic [7:0]  MIN_LENGTH = 8'd4;

    typedef enum logic [2:0] {
        ROLE_LENGTH  = 3'd0,
        ROLE_COMMAND = 3'd1,
        ROLE_STATUS  = 3'd2,
        ROLE_PAYLOAD = 3'd3,
        ROLE_CRC_HI  = 3'd4,
        ROLE_CRC_LO  = 3'd5,
        ROLE_BAD_LEN = 3'd6
    } role_t;

    typedef struct packed {
        logic [7:0] value;
        role_t      role;
    } item_t;

    typedef struct packed {
        logic [7:0] value;
        role_t      role;
        logic       frame_end;
        logic       crc_match;
    } result_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

>>> hdl/lfcrc_front.sv
// ----------------------------------------------------------------------------
// lfcrc_front
// Tracks the position within a frame and tags each incoming word with its
// role before handing it to the queue.
// ----------------------------------------------------------------------------
module lfcrc_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,    // [7:0] rx_byte
    output logic                push_valid,
    input  logic                push_ready,
    output lfcrc_pkg::item_t    push_item
);

    logic [7:0]       pos_reg, pos_next;
    logic [7:0]       len_reg, len_next;
    lfcrc_pkg::role_t role;
    logic             accept;

    assign s_tready   = push_ready;
    assign push_valid = s_tvalid;
    assign accept     = s_tvalid && push_ready;

    always_comb
    begin
        pos_next = pos_reg;
        len_next = len_reg;
        role     = lfcrc_pkg::ROLE_PAYLOAD;
        priority if (pos_reg == 8'd0)
        begin
            if (s_tdata < lfcrc_pkg::MIN_LENGTH)
            begin
                role = lfcrc_pkg::ROLE_BAD_LEN;
            end
            else
            begin
                role     = lfcrc_pkg::ROLE_LENGTH;
                len_next = s_tdata;
                pos_next = 8'd1;
            end
        end
        else if (pos_reg == len_reg - 8'd1)
        begin
            role     = lfcrc_pkg::ROLE_CRC_HI;
            pos_next = pos_reg + 8'd1;
        end
        else if (pos_reg >= len_reg)
        begin
            role     = lfcrc_pkg::ROLE_CRC_LO;
            pos_next = 8'd0;
            len_next = 8'd0;
        end
        else
        begin
            if (pos_reg == 8'd1)
                role = lfcrc_pkg::ROLE_COMMAND;
            else if (pos_reg == 8'd2)
                role = lfcrc_pkg::ROLE_STATUS;
            else
                role = lfcrc_pkg::ROLE_PAYLOAD;
            pos_next = pos_reg + 8'd1;
        end
    end

    assign push_item.value = s_tdata;
    assign push_item.role  = role;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= 8'd0;
            len_reg <= 8'd0;
        end
        else if (accept)
        begin
            pos_reg <= pos_next;
            len_reg <= len_next;
        end
    end

    a_len_valid_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg != 8'd0) |-> (len_reg >= lfcrc_pkg::MIN_LENGTH))
        else $error("frame in progress with length below minimum");

endmodule

>>> hdl/lfcrc_fifo.sv
// ----------------------------------------------------------------------------
// lfcrc_fifo
// Short queue of tagged words between the classifier and the CRC checker.
// ----------------------------------------------------------------------------
module lfcrc_fifo
#(
    parameter int unsigned DEPTH = lfcrc_pkg::FIFO_DEPTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  lfcrc_pkg::item_t    push_item,
    output logic                pop_valid,
    input  logic                pop_ready,
    output lfcrc_pkg::item_t    pop_item
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    lfcrc_pkg::item_t mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             push, pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        if (push && !pop)
            count_next = count_reg + CW'(1);
        else if (pop && !push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == CW'(DEPTH)) && !pop |=> (count_reg == CW'(DEPTH)) && !push_ready)
        else $error("queue state changed while full without a pop");

endmodule

>>> hdl/lfcrc_back.sv
// ----------------------------------------------------------------------------
// lfcrc_back
// Runs the CRC over tagged words, compares at the CRC low word and holds
// the result in the output register.
// ----------------------------------------------------------------------------
module lfcrc_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  lfcrc_pkg::item_t    pop_item,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,    // [7:0] byte_value
    output logic [3:0]          m_tuser,    // [2:0] byte_role, [3] crc_match
    output logic                m_tlast     // frame_end
);

    logic                 out_valid_reg;
    lfcrc_pkg::result_t   out_reg, out_next;
    logic [15:0]          crc_reg, crc_next;
    logic [7:0]           crc_hi_reg, crc_hi_next;
    logic                 pop;

    assign pop_ready = !out_valid_reg || m_tready;
    assign pop       = pop_valid && pop_ready;

    always_comb
    begin
        crc_next           = crc_reg;
        crc_hi_next        = crc_hi_reg;
        out_next.value     = pop_item.value;
        out_next.role      = pop_item.role;
        out_next.frame_end = 1'b0;
        out_next.crc_match = 1'b0;
        unique case (pop_item.role)
            lfcrc_pkg::ROLE_LENGTH:
            begin
                crc_next = lfcrc_pkg::crc_feed(lfcrc_pkg::CRC_PRESET, pop_item.value);
            end
            lfcrc_pkg::ROLE_COMMAND, lfcrc_pkg::ROLE_STATUS, lfcrc_pkg::ROLE_PAYLOAD:
            begin
                crc_next = lfcrc_pkg::crc_feed(crc_reg, pop_item.value);
            end
            lfcrc_pkg::ROLE_CRC_HI:
            begin
                crc_hi_next = pop_item.value;
            end
            lfcrc_pkg::ROLE_CRC_LO:
            begin
                out_next.frame_end = 1'b1;
                out_next.crc_match = ({crc_hi_reg, pop_item.value} == crc_reg);
                crc_next           = lfcrc_pkg::CRC_PRESET;
                crc_hi_next        = 8'd0;
            end
            default:
            begin
                crc_next    = lfcrc_pkg::CRC_PRESET;
                crc_hi_next = 8'd0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            crc_reg       <= lfcrc_pkg::CRC_PRESET;
            crc_hi_reg    <= 8'd0;
        end
        else
        begin
            if (pop_ready)
                out_valid_reg <= pop_valid;
            if (pop)
            begin
                crc_reg    <= crc_next;
                crc_hi_reg <= crc_hi_next;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.value;
    assign m_tuser  = {out_reg.crc_match, out_reg.role};
    assign m_tlast  = out_reg.frame_end;

    a_match_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.crc_match |-> out_reg.frame_end
            && (out_reg.role == lfcrc_pkg::ROLE_CRC_LO))
        else $error("crc_match set outside frame end");

    a_crc_preset_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        pop && (pop_item.role == lfcrc_pkg::ROLE_CRC_LO)
            |=> (crc_reg == lfcrc_pkg::CRC_PRESET) && (crc_hi_reg == 8'd0))
        else $error("crc state not preset after frame end");

endmodule

>>> hdl/length_framed_crc16_response_checker.sv
// ----------------------------------------------------------------------------
// length_framed_crc16_response_checker
// Tags received words by their role in a length-prefixed response frame and
// checks the CRC-16 (reflected 0x8408, preset 0xFFFF) at frame end.
//
//   channel  dir  tdata             tuser                        tlast
//   s_*      in   [7:0] rx_byte     -                            -
//   m_*      out  [7:0] byte_value  [2:0] byte_role,[3] crc_match frame_end
//
// One word per cycle sustained unless the output stalls; words pass through
// the queue and then the output register. The classifier and the CRC unit
// each take a word a cycle unless back-pressured. Reset is asynchronous,
// active low, and clears frame tracking, CRC state, the queue and the output
// valid. A stalled output fills the queue, after which s_tready drops.
// ----------------------------------------------------------------------------
module length_framed_crc16_response_checker
#(
    parameter int unsigned FIFO_DEPTH = lfcrc_pkg::FIFO_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] byte_value
    output logic [3:0]  m_tuser,    // [2:0] byte_role, [3] crc_match
    output logic        m_tlast     // frame_end
);

    logic             push_valid, push_ready;
    lfcrc_pkg::item_t push_item;
    logic             pop_valid, pop_ready;
    lfcrc_pkg::item_t pop_item;

    lfcrc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    lfcrc_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    lfcrc_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule
